/* rtl/route_longest_prefix_lookup_core_assert.svh */
// ---------------------------------------------------------------------------
// route lookup assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef ROUTE_LONGEST_PREFIX_LOOKUP_CORE_ASSERT_SVH
`define ROUTE_LONGEST_PREFIX_LOOKUP_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RLPL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlpl assertion failed");

// antecedent implies consequent in the next cycle
`define RLPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlpl assertion failed");

`endif

/* rtl/rlpl_pkg.sv */
// ---------------------------------------------------------------------------
// rlpl_pkg
// types and codes shared by the route lookup block
// ---------------------------------------------------------------------------
package rlpl_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned ENT_IDX_W = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SRC_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_VALID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L3_CAPABLE    = 2'd2;

  // item function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // result source codes
  localparam logic [SRC_W-1:0] SRC_NONE    = 2'd0;
  localparam logic [SRC_W-1:0] SRC_TABLE   = 2'd1;
  localparam logic [SRC_W-1:0] SRC_GATEWAY = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] next_hop;
  } rlpl_entry_t;

  localparam int unsigned ENTRY_W = $bits(rlpl_entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } rlpl_state_e;

endpackage

/* rtl/rlpl_ram.sv */
// ---------------------------------------------------------------------------
// rlpl_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module rlpl_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rlpl_match.sv */
// ---------------------------------------------------------------------------
// rlpl_match
// shared compare unit: prefix match of one stored route against the target
// ---------------------------------------------------------------------------
module rlpl_match
  import rlpl_pkg::*;
(
  input  logic [ADDR_W-1:0] target_i,
  input  rlpl_entry_t       entry_i,
  input  logic              valid_i,
  input  logic [ADDR_W-1:0] best_mask_i,
  output logic              take_o
);

  logic prefix_eq;

  assign prefix_eq = ((target_i ^ entry_i.dest) & entry_i.mask) == '0;
  // strictly larger mask wins, so earlier entries keep ties and zero masks never win
  assign take_o    = valid_i && prefix_eq && (entry_i.mask > best_mask_i);

endmodule

/* rtl/route_longest_prefix_lookup_core.sv */
// ---------------------------------------------------------------------------
// route_longest_prefix_lookup_core
// ipv4 longest prefix match over a small route table with default gateway
// ---------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser selects a route write or a lookup.
// A write stores one entry into the route ram and returns an all-zero result
// without a table scan. A lookup reads one entry per cycle from the route
// ram and runs it through a single compare unit; after the last read a drain
// state lets its data reach the compare before the result is loaded into the
// output register. With the table search switched off a lookup skips the
// scan. One item is in flight at a time; s_axis_tready is low while it is
// worked on.
// A finished result sits in the output register until taken; the block takes
// the next item meanwhile and holds its result back while m_axis stalls.
// Reset clears all entry valid bits, the gateway registers and the output valid flag;
// no clearing pass is needed, the table is usable straight away.
// Configuration writes (gateway address, gateway valid, l3 capable) must be
// made while the block is idle.
// ---------------------------------------------------------------------------
`include "route_longest_prefix_lookup_core_assert.svh"

module route_longest_prefix_lookup_core
  import rlpl_pkg::*;
#(
  parameter int unsigned ROUTE_ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  // input channel
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // entry_index, entry_valid, route_dest, route_mask, route_next_hop, target_ip
  input  logic [135:0]         s_axis_tdata,
  // func
  input  logic [0:0]           s_axis_tuser,
  // output channel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // found, next_hop_ip, matched_mask
  output logic [71:0]          m_axis_tdata,
  // route_source
  output logic [SRC_W-1:0]     m_axis_tuser
);

  localparam int unsigned IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

  // input unpacking
  logic [ENT_IDX_W-1:0] in_entry_index;
  logic                 in_entry_valid;
  rlpl_entry_t          in_entry;
  logic [ADDR_W-1:0]    in_target;
  logic                 in_func;

  assign in_entry_index    = s_axis_tdata[3:0];
  assign in_entry_valid    = s_axis_tdata[4];
  assign in_entry.dest     = s_axis_tdata[36:5];
  assign in_entry.mask     = s_axis_tdata[68:37];
  assign in_entry.next_hop = s_axis_tdata[100:69];
  assign in_target         = s_axis_tdata[132:101];
  assign in_func           = s_axis_tuser[0];

  // config registers
  logic [ADDR_W-1:0] gw_ip_q;
  logic              gw_valid_q;
  logic              l3_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_ip_q    <= '0;
      gw_valid_q <= 1'b0;
      l3_cap_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GATEWAY_IP:    gw_ip_q    <= cfg_data_i;
        REG_GATEWAY_VALID: gw_valid_q <= cfg_data_i[0];
        REG_L3_CAPABLE:    l3_cap_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  rlpl_state_e state_q, state_d;
  logic        in_acc;
  logic        out_free;
  logic        ram_re;
  logic        out_load;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  logic [IDX_W-1:0] cnt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func == FUNC_LOOKUP && l3_cap_q) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SCAN:  ram_re        = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // route table: valid bits in flops, entries in ram
  logic [ENT_IDX_W+IDX_W-1:0] wr_idx_ext;
  logic [IDX_W-1:0]           wr_addr;
  logic                       wr_in_range;
  logic                       ram_we;
  logic [ROUTE_ENTRIES-1:0]   valid_q;
  rlpl_entry_t                rd_entry;

  assign wr_idx_ext  = {{IDX_W{1'b0}}, in_entry_index};
  assign wr_addr     = wr_idx_ext[IDX_W-1:0];
  assign wr_in_range = 32'(in_entry_index) < 32'(ROUTE_ENTRIES);
  assign ram_we      = in_acc && (in_func == FUNC_WRITE) && wr_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[wr_addr] <= in_entry_valid;
    end
  end

  rlpl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ROUTE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (in_entry),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (rd_entry)
  );

  // scan bookkeeping: read data arrives in the cycle after its address
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= ram_re;
      if (in_acc) begin
        cnt_q <= '0;
      end else if (ram_re) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
  end

  // best route so far; a nonzero best mask means a table hit
  logic [ADDR_W-1:0] target_q;
  logic              lookup_q;
  logic [ADDR_W-1:0] best_mask_q;
  logic [ADDR_W-1:0] best_hop_q;
  logic              take;

  rlpl_match u_match (
    .target_i    (target_q),
    .entry_i     (rd_entry),
    .valid_i     (rd_pend_q && valid_q[rd_idx_q]),
    .best_mask_i (best_mask_q),
    .take_o      (take)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      target_q    <= in_target;
      lookup_q    <= in_func == FUNC_LOOKUP;
      best_mask_q <= '0;
      best_hop_q  <= '0;
    end else if (take) begin
      best_mask_q <= rd_entry.mask;
      best_hop_q  <= rd_entry.next_hop;
    end
  end

  // result selection
  logic              hit;
  logic              res_found;
  logic [ADDR_W-1:0] res_hop;
  logic [ADDR_W-1:0] res_mask;
  logic [SRC_W-1:0]  res_src;

  assign hit = best_mask_q != '0;

  always_comb begin
    res_found = 1'b0;
    res_hop   = '0;
    res_mask  = '0;
    res_src   = SRC_NONE;
    if (lookup_q) begin
      if (hit) begin
        res_found = 1'b1;
        res_hop   = best_hop_q;
        res_mask  = best_mask_q;
        res_src   = SRC_TABLE;
      end else if (gw_valid_q) begin
        res_found = 1'b1;
        res_hop   = gw_ip_q;
        res_src   = SRC_GATEWAY;
      end
    end
  end

  // output register
  logic              m_valid_q;
  logic              o_found_q;
  logic [ADDR_W-1:0] o_hop_q;
  logic [ADDR_W-1:0] o_mask_q;
  logic [SRC_W-1:0]  o_src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_found_q <= res_found;
      o_hop_q   <= res_hop;
      o_mask_q  <= res_mask;
      o_src_q   <= res_src;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, o_mask_q, o_hop_q, o_found_q};
  assign m_axis_tuser  = o_src_q;

  // checks
  `RLPL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready)
  `RLPL_ASSERT_SAME(a_table_has_mask, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == SRC_TABLE), m_axis_tdata[64:33] != '0)
  `RLPL_ASSERT_SAME(a_none_is_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == SRC_NONE), m_axis_tdata == '0)

endmodule
